[sv/polled_meter_request_engine_assert.svh]
// Assertion macros used by the request engine back end.
`ifndef POLLED_METER_REQUEST_ENGINE_ASSERT_SVH
`define POLLED_METER_REQUEST_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PMRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PMRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pmre_pkg.sv]
// Types and constants of the polled meter request engine.
`timescale 1ns / 1ps
package pmre_pkg;

  localparam int REQUEST_COUNT  = 5;
  localparam int FRAME_COUNT    = 5;
  localparam int TIMEOUT_PASSES = 20;
  localparam int FRAME_BYTES    = 6;
  localparam int RX_LEN         = 7;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam int IDX_W   = 3;
  localparam int CFG_W   = 48;
  localparam int TO_W    = 5;
  localparam int CNT_W   = 3;
  localparam int HUND_W  = 31;

  localparam logic [REQUEST_COUNT-1:0] REQ_MASK = '1;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_INT_MASK = 3'd5;
  localparam logic [IDX_W-1:0] CFG_INTERVAL = 3'd6;

  localparam logic [31:0] INTERVAL_RESET = 32'd1000;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_TIMEOUT = 2'd1,
    EV_CKSUM   = 2'd2,
    EV_READING = 2'd3
  } event_e;

  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic [7:0]  rx_byte;
  } in_word_t;

  typedef struct packed {
    logic              tx_valid;
    logic [7:0]        tx_byte;
    event_e            event_res;
    logic [IDX_W-1:0]  reading_index;
    logic [HUND_W-1:0] reading_hundredths;
    logic              initialized;
    logic              last;
  } out_word_t;

  // one loop pass, as handed from front to back
  typedef struct packed {
    logic              has_tx;
    logic [CFG_W-1:0]  frame;
    logic [IDX_W-1:0]  tx_idx;
    event_e            ev;
    logic [IDX_W-1:0]  ev_idx;
    logic [HUND_W-1:0] hund;
    logic              init;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_rd_t;

endpackage

[sv/pmre_front.sv]
// Front end: accepts words, schedules requests, tracks replies, queues passes.
`timescale 1ns / 1ps
module pmre_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  pmre_pkg::in_word_t       in_data_i,
  input  logic                     cfg_we_i,
  input  logic [pmre_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [pmre_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output pmre_pkg::job_t           q_job_o
);
  import pmre_pkg::*;

  logic [CFG_W-1:0]         frame_q [FRAME_COUNT];
  logic [FRAME_COUNT-1:0]   int_mask_q;
  logic [31:0]              interval_q;

  logic [REQUEST_COUNT-1:0] pend_q, pend_d;
  logic                     busy_q, busy_d;
  logic [IDX_W-1:0]         bidx_q, bidx_d;
  logic [TO_W-1:0]          tc_q, tc_d;
  logic [31:0]              last_poll_q, last_poll_d;
  logic                     due_q, due_d;
  logic [REQUEST_COUNT-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]         rx_cnt_q, rx_cnt_d;
  logic [7:0]               rx_sum_q, rx_sum_d;
  logic [7:0]               rx_buf_q [RX_LEN];

  logic accept_s, rx_wr_s;
  job_t job_s;

  assign in_stall_o = q_full_i;
  assign accept_s   = in_valid_i && !in_stall_o;
  assign rx_wr_s    = accept_s && in_data_i.command && (rx_cnt_q < CNT_W'(RX_LEN));

  always_comb begin
    logic [REQUEST_COUNT-1:0] pend_s;
    logic [IDX_W-1:0]         sel_s;
    logic                     send_s;
    logic                     busy_s;
    logic [CNT_W-1:0]         rc_s;
    logic [TO_W-1:0]          tc_s;
    logic [31:0]              elapsed_s;
    logic                     int_fmt_s;
    logic [23:0]              op_s;
    logic [7:0]               add_s;
    logic [HUND_W-1:0]        prod_s;

    pend_d      = pend_q;
    busy_d      = busy_q;
    bidx_d      = bidx_q;
    tc_d        = tc_q;
    last_poll_d = last_poll_q;
    due_d       = due_q;
    valid_d     = valid_q;
    rx_cnt_d    = rx_cnt_q;
    rx_sum_d    = rx_sum_q;

    pend_s    = pend_q;
    sel_s     = '0;
    send_s    = 1'b0;
    busy_s    = busy_q;
    rc_s      = rx_cnt_q;
    tc_s      = tc_q;
    elapsed_s = in_data_i.now_ms - last_poll_q;
    int_fmt_s = 1'b0;

    for (int i = 0; i < FRAME_COUNT; i++) begin
      if (bidx_q == IDX_W'(i)) int_fmt_s = int_mask_q[i];
    end
    op_s   = int_fmt_s ? {rx_buf_q[1], rx_buf_q[2], rx_buf_q[3]}
                       : {8'h00, rx_buf_q[1], rx_buf_q[2]};
    add_s  = int_fmt_s ? 8'h00 : rx_buf_q[3];
    prod_s = HUND_W'({7'd0, op_s} * 31'd100) + HUND_W'(add_s);

    job_s        = '0;
    job_s.ev     = EV_NONE;

    if (rx_wr_s) begin
      rx_cnt_d = rx_cnt_q + CNT_W'(1);
      // running sum over the first six bytes; a flush leaves the count at zero
      if (rx_cnt_q < CNT_W'(FRAME_BYTES)) begin
        rx_sum_d = ((rx_cnt_q == '0) ? 8'h00 : rx_sum_q) + in_data_i.rx_byte;
      end
    end

    if (accept_s && !in_data_i.command) begin
      // schedule
      if (valid_q[0]) begin
        if (due_q || (elapsed_s >= interval_q)) begin
          pend_s      = pend_s | (REQ_MASK & ~REQUEST_COUNT'(1));
          last_poll_d = in_data_i.now_ms;
          due_d       = 1'b0;
        end
      end else if (!(busy_q && bidx_q == '0)) begin
        pend_s[0] = 1'b1;
      end

      // send
      for (int i = REQUEST_COUNT - 1; i >= 0; i--) begin
        if (pend_s[i]) sel_s = IDX_W'(i);
      end
      if (!busy_q && (pend_s != '0)) begin
        send_s        = 1'b1;
        rc_s          = '0;
        busy_s        = 1'b1;
        bidx_d        = sel_s;
        pend_s[sel_s] = 1'b0;
        tc_s          = TO_W'(TIMEOUT_PASSES);
        job_s.has_tx  = 1'b1;
        job_s.tx_idx  = sel_s;
        for (int i = 0; i < FRAME_COUNT; i++) begin
          if (sel_s == IDX_W'(i)) job_s.frame = frame_q[i];
        end
      end

      // receive
      if (busy_s) begin
        if (rc_s < CNT_W'(RX_LEN)) begin
          tc_s = tc_s - TO_W'(1);
          if (tc_s == '0) begin
            busy_s       = 1'b0;
            job_s.ev     = EV_TIMEOUT;
            job_s.ev_idx = send_s ? sel_s : bidx_q;
          end
        end else begin
          busy_s       = 1'b0;
          rc_s         = '0;
          job_s.ev_idx = bidx_q;
          if (rx_sum_q != rx_buf_q[RX_LEN-1]) begin
            job_s.ev = EV_CKSUM;
          end else begin
            job_s.ev       = EV_READING;
            job_s.hund     = prod_s;
            valid_d[bidx_q[IDX_W-1:0]] = 1'b1;
          end
        end
      end

      pend_d   = pend_s;
      busy_d   = busy_s;
      tc_d     = tc_s;
      rx_cnt_d = rc_s;
    end

    job_s.init = valid_d[0];
  end

  assign q_push_o = accept_s && !in_data_i.command;
  assign q_job_o  = job_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      busy_q      <= 1'b0;
      bidx_q      <= '0;
      tc_q        <= '0;
      last_poll_q <= '0;
      due_q       <= 1'b1;
      valid_q     <= '0;
      rx_cnt_q    <= '0;
      rx_sum_q    <= '0;
      int_mask_q  <= '0;
      interval_q  <= INTERVAL_RESET;
      for (int i = 0; i < FRAME_COUNT; i++) frame_q[i] <= '0;
    end else begin
      pend_q      <= pend_d;
      busy_q      <= busy_d;
      bidx_q      <= bidx_d;
      tc_q        <= tc_d;
      last_poll_q <= last_poll_d;
      due_q       <= due_d;
      valid_q     <= valid_d;
      rx_cnt_q    <= rx_cnt_d;
      rx_sum_q    <= rx_sum_d;
      if (cfg_we_i) begin
        for (int i = 0; i < FRAME_COUNT; i++) begin
          if (cfg_idx_i == IDX_W'(i)) frame_q[i] <= cfg_data_i;
        end
        if (cfg_idx_i == CFG_INT_MASK) int_mask_q <= cfg_data_i[FRAME_COUNT-1:0];
        if (cfg_idx_i == CFG_INTERVAL) interval_q <= cfg_data_i[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_wr_s) rx_buf_q[rx_cnt_q] <= in_data_i.rx_byte;
  end

endmodule

[sv/pmre_fifo.sv]
// Short job queue between front and back.
`timescale 1ns / 1ps
module pmre_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pmre_pkg::q_wr_t wr_i,
  input  pmre_pkg::job_t  wr_job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output pmre_pkg::job_t  rd_job_o
);
  import pmre_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push_s, do_pop_s;

  assign full_o    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_push_s = wr_i.push && !wr_i.full;
  assign do_pop_s  = pop_i && !empty_o;
  assign rd_job_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push_s) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop_s) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    case ({do_push_s, do_pop_s})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push_s) mem_q[wr_ptr_q] <= wr_job_i;
  end

endmodule

[sv/pmre_back.sv]
// Back end: expands queued passes into transmit words and a status word.
`timescale 1ns / 1ps
module pmre_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pmre_pkg::q_rd_t     q_i,
  input  pmre_pkg::job_t      job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pmre_pkg::out_word_t out_data_o
);
  import pmre_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       sum_q, sum_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, out_d;
  logic             load_s;
  logic [7:0]       byte_s;

  assign load_s = !q_i.empty && (!out_valid_q || !out_stall_i);
  assign byte_s = 8'(job_i.frame >> (CFG_W - 8 - 8 * int'(cnt_q)));

  always_comb begin
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;
    if (load_s) begin
      out_valid_d       = 1'b1;
      out_d             = '0;
      out_d.event_res   = EV_NONE;
      out_d.initialized = job_i.init;
      if (job_i.has_tx && cnt_q < CNT_W'(RX_LEN)) begin
        out_d.tx_valid      = 1'b1;
        out_d.reading_index = job_i.tx_idx;
        if (cnt_q < CNT_W'(FRAME_BYTES)) begin
          out_d.tx_byte = byte_s;
          sum_d         = ((cnt_q == '0) ? 8'h00 : sum_q) + byte_s;
        end else begin
          out_d.tx_byte = sum_q;   // checksum closes the frame
        end
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        out_d.event_res          = job_i.ev;
        out_d.reading_index      = job_i.ev_idx;
        out_d.reading_hundredths = job_i.hund;
        out_d.last               = 1'b1;
        cnt_d                    = '0;
        pop_o                    = 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    out_q <= out_d;
  end

`include "polled_meter_request_engine_assert.svh"

  `PMRE_ASSERT_NEXT(a_pop_restarts, pop_o, cnt_q == '0, "byte counter not cleared after pop")
  `PMRE_ASSERT_NOW(a_mid_frame_job, cnt_q != '0, !q_i.empty, "frame in progress without a job")
  `PMRE_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CNT_W'(RX_LEN), "byte counter out of range")
  `PMRE_ASSERT_NOW(a_pop_only_status, pop_o, out_d.last && !out_d.tx_valid, "pop on a tx word")
  `PMRE_ASSERT_NOW(a_pop_loopback, 1'b1, q_i.pop == pop_o, "queue pop differs from request")

endmodule

[sv/polled_meter_request_engine.sv]
// Polled meter request engine: accepts one word per cycle while the job queue has room.
// A loop pass is written into the job queue, then loaded into the back end output register.
// A pass that sends a request yields 8 words (7 transmit, 1 status), one per cycle while not stalled;
// other passes yield one status word; received bytes yield none.
// Sustained rate is set by the back end output register, one word per cycle while out_stall_i is low.
// Reset clears the control state at once but sets the poll-due flag; config registers take their reset values.
`timescale 1ns / 1ps
module polled_meter_request_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  pmre_pkg::in_word_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output pmre_pkg::out_word_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic [pmre_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [pmre_pkg::CFG_W-1:0] cfg_data_i
);
  import pmre_pkg::*;

  job_t  push_job_s, pop_job_s;
  q_wr_t q_wr_s;
  q_rd_t q_rd_s;
  logic  push_s, full_s, empty_s, pop_s;

  assign q_wr_s.push  = push_s;
  assign q_wr_s.full  = full_s;
  assign q_rd_s.pop   = pop_s;
  assign q_rd_s.empty = empty_s;

  pmre_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_wr_s.full),
    .q_push_o   (push_s),
    .q_job_o    (push_job_s)
  );

  pmre_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr_s),
    .wr_job_i (push_job_s),
    .full_o   (full_s),
    .pop_i    (q_rd_s.pop),
    .empty_o  (empty_s),
    .rd_job_o (pop_job_s)
  );

  pmre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_i         (q_rd_s),
    .job_i       (pop_job_s),
    .pop_o       (pop_s),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[tb/tb_polled_meter_request_engine.sv]
// Self-checking testbench for the polled meter request engine.
`timescale 1ns / 1ps
module tb_polled_meter_request_engine;
  import pmre_pkg::*;

  localparam logic             CMD_PASS      = 1'b0;
  localparam logic             CMD_BYTE      = 1'b1;
  localparam logic [IDX_W-1:0] CFG_UNUSED    = 3'd7;
  localparam int               CYCLE_LIMIT   = 400000;
  localparam int               SETTLE_CYCLES = 12;
  localparam int               SHOW_LIMIT    = 40;

  // Tracks the engine state and holds the result words still owed by the DUT.
  class meter_poll_board;
    logic [CFG_W-1:0]         frame [FRAME_COUNT] = '{default: '0};
    logic [4:0]               int_mask = '0;
    logic [31:0]              interval_ms = INTERVAL_RESET;
    logic [REQUEST_COUNT-1:0] pending = '0;
    logic [REQUEST_COUNT-1:0] valid_bits = '0;
    bit                       busy = 1'b0;
    logic [IDX_W-1:0]         busy_idx = '0;
    logic [TO_W-1:0]          passes_left = '0;
    logic [31:0]              last_poll = '0;
    bit                       poll_due = 1'b1;
    logic [7:0]               rx_buf [RX_LEN] = '{default: '0};
    int                       rx_held = 0;
    out_word_t                words_due [$];
    int                       words_in = 0;
    int                       passes = 0;
    int                       words_out = 0;
    int                       mismatches = 0;
    int                       events [4] = '{default: 0};

    function void set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      if (idx < FRAME_COUNT) frame[idx] = value;
      else if (idx == CFG_INT_MASK) int_mask = value[4:0];
      else if (idx == CFG_INTERVAL) interval_ms = value[31:0];
    endfunction

    function void queue_word(input logic tx, input logic [7:0] tx_byte, input event_e ev,
                             input logic [IDX_W-1:0] idx, input logic [HUND_W-1:0] hund,
                             input logic fin);
      out_word_t w;
      w.tx_valid           = tx;
      w.tx_byte            = tx_byte;
      w.event_res          = ev;
      w.reading_index      = idx;
      w.reading_hundredths = hund;
      w.initialized        = valid_bits[0];
      w.last               = fin;
      words_due.push_back(w);
    endfunction

    function void note_word(input in_word_t w);
      event_e            ev;
      logic [IDX_W-1:0]  ev_idx;
      logic [HUND_W-1:0] hund;
      logic [7:0]        sum;
      logic [7:0]        b;
      int                sel;
      int                i;
      words_in++;
      if (w.command == CMD_BYTE) begin
        if (rx_held < RX_LEN) begin
          rx_buf[rx_held] = w.rx_byte;
          rx_held++;
        end
        return;
      end
      passes++;
      ev = EV_NONE;
      ev_idx = '0;
      hund = '0;
      // schedule
      if (valid_bits[0]) begin
        if (poll_due || ((w.now_ms - last_poll) >= interval_ms)) begin
          pending[REQUEST_COUNT-1:1] = '1;
          last_poll = w.now_ms;
          poll_due = 1'b0;
        end
      end else if (!(busy && busy_idx == 0) && !pending[0]) begin
        pending[0] = 1'b1;
      end
      // send lowest pending request
      if (!busy && pending != '0) begin
        sel = 0;
        for (i = REQUEST_COUNT - 1; i >= 0; i--) if (pending[i]) sel = i;
        rx_held = 0;
        sum = '0;
        for (i = 0; i < FRAME_BYTES; i++) begin
          b = frame[sel][CFG_W-1-8*i -: 8];
          sum += b;
          queue_word(1'b1, b, EV_NONE, IDX_W'(sel), '0, 1'b0);
        end
        queue_word(1'b1, sum, EV_NONE, IDX_W'(sel), '0, 1'b0);
        busy = 1'b1;
        busy_idx = IDX_W'(sel);
        pending[sel] = 1'b0;
        passes_left = TO_W'(TIMEOUT_PASSES);
      end
      // receive
      if (busy) begin
        if (rx_held < RX_LEN) begin
          passes_left--;
          if (passes_left == 0) begin
            busy = 1'b0;
            ev = EV_TIMEOUT;
            ev_idx = busy_idx;
          end
        end else begin
          busy = 1'b0;
          rx_held = 0;
          ev_idx = busy_idx;
          sum = '0;
          for (i = 0; i < FRAME_BYTES; i++) sum += rx_buf[i];
          if (sum != rx_buf[RX_LEN-1]) begin
            ev = EV_CKSUM;
          end else begin
            if (int_mask[busy_idx]) hund = HUND_W'({rx_buf[1], rx_buf[2], rx_buf[3]} * 100);
            else hund = HUND_W'({rx_buf[1], rx_buf[2]} * 100 + rx_buf[3]);
            ev = EV_READING;
            valid_bits[busy_idx] = 1'b1;
          end
        end
      end
      events[ev]++;
      queue_word(1'b0, 8'h00, ev, ev_idx, hund, 1'b1);
    endfunction

    function void check_word(input out_word_t got);
      out_word_t want;
      words_out++;
      if (words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: word out with none expected: tx %0b byte %02h ev %0d idx %0d hund %0d",
                   $time, got.tx_valid, got.tx_byte, got.event_res, got.reading_index,
                   got.reading_hundredths);
        return;
      end
      want = words_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
          $display("%0t: word %0d expected tx %0b byte %02h ev %0d idx %0d hund %0d init %0b last %0b",
                   $time, words_out, want.tx_valid, want.tx_byte, want.event_res,
                   want.reading_index, want.reading_hundredths, want.initialized, want.last);
          $display("%0t: word %0d actual   tx %0b byte %02h ev %0d idx %0d hund %0d init %0b last %0b",
                   $time, words_out, got.tx_valid, got.tx_byte, got.event_res,
                   got.reading_index, got.reading_hundredths, got.initialized, got.last);
        end
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  in_word_t         in_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_word_t        out_data_o;
  logic             cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  meter_poll_board board;
  int              send_idle_pct = 13;
  int              recv_stall_pct = 78;
  int              cycle_count = 0;
  logic [31:0]     ms_clock = '0;

  polled_meter_request_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_polled_meter_request_engine: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_word(out_data_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_word(w);
  endtask

  task automatic loop_pass(input logic [31:0] now);
    in_word_t w;
    w.command = CMD_PASS;
    w.now_ms = now;
    w.rx_byte = 8'($urandom);
    send_word(w);
  endtask

  task automatic meter_byte(input logic [7:0] b);
    in_word_t w;
    w.command = CMD_BYTE;
    w.now_ms = $urandom;
    w.rx_byte = b;
    send_word(w);
  endtask

  // Time steps land on or just short of the poll deadline, step on by up to 60, or jump to a random value.
  function automatic logic [31:0] next_time();
    int r;
    r = $urandom_range(99);
    if (r < 30) ms_clock = board.last_poll + board.interval_ms;
    else if (r < 40) ms_clock = board.last_poll + board.interval_ms - 32'd1;
    else if (r < 92) ms_clock = ms_clock + 32'($urandom_range(0, 60));
    else ms_clock = $urandom;
    return ms_clock;
  endfunction

  task automatic write_settings(input logic [CFG_W-1:0] frames [FRAME_COUNT],
                                input logic [4:0] mask, input logic [31:0] interval);
    logic [CFG_W-1:0] value;
    logic [IDX_W-1:0] idx;
    int               k;
    for (k = 0; k <= int'(CFG_UNUSED); k++) begin
      idx = IDX_W'(k);
      value = CFG_W'({$urandom, $urandom});
      if (idx < FRAME_COUNT) value = frames[k];
      else if (idx == CFG_INT_MASK) value[4:0] = mask;
      else if (idx == CFG_INTERVAL) value[31:0] = interval;
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_data_i <= value;
      @(posedge clk_i);
      board.set_reg(idx, value);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random(input int count);
    int         stop_at;
    int         pick;
    int         n;
    int         i;
    logic [7:0] reply [RX_LEN];
    logic [7:0] sum;
    stop_at = board.words_in + count;
    while (board.words_in < stop_at) begin
      pick = $urandom_range(99);
      if (!board.busy) begin
        if (pick < 88) loop_pass(next_time());
        else meter_byte(8'($urandom));  // stray word, flushed by the next send
      end else if (pick < 10 || (!board.valid_bits[0] && board.events[EV_TIMEOUT] == 0)) begin
        // partial reply, then passes until the request is dropped
        n = $urandom_range(0, RX_LEN - 1);
        while (board.rx_held < n) meter_byte(8'($urandom));
        while (board.busy) loop_pass(next_time());
      end else begin
        sum = '0;
        for (i = 0; i < RX_LEN - 1; i++) begin
          if (i >= 1 && i <= 3 && pick % 4 == 0) reply[i] = 8'hFF;
          else if (i >= 1 && i <= 3 && pick % 4 == 1) reply[i] = 8'h00;
          else reply[i] = 8'($urandom);
          sum += reply[i];
        end
        reply[RX_LEN-1] = (pick < 25) ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        for (i = 0; i < RX_LEN; i++) begin
          if ($urandom_range(15) == 0) loop_pass(next_time());
          meter_byte(reply[i]);
        end
        // bytes past the seventh are dropped
        if (pick > 88) repeat ($urandom_range(1, 3)) meter_byte(8'($urandom));
        loop_pass(next_time());
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] frames [FRAME_COUNT];
    int               k;
    board = new;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    frames[0] = '1;
    frames[1] = '0;
    for (k = 2; k < FRAME_COUNT; k++) frames[k] = CFG_W'({$urandom, $urandom});
    write_settings(frames, 5'h00, 32'd0);

    // request 0 goes out at once; answer it with a bad checksum
    loop_pass(32'h0000_0000);
    meter_byte(8'h00);
    meter_byte(8'hFF);
    meter_byte(8'h00);
    meter_byte(8'hFF);
    meter_byte(8'h12);
    meter_byte(8'h34);
    meter_byte(8'h00);
    loop_pass(32'hFFFF_FFFF);
    // request 0 is resent after the failure
    loop_pass(32'hFFFF_FFFF);

    run_random(107);
    settle();

    send_idle_pct = 78;
    recv_stall_pct = 13;
    for (k = 0; k < FRAME_COUNT; k++) frames[k] = CFG_W'({$urandom, $urandom});
    write_settings(frames, 5'h1F, 32'($urandom_range(1, 3000)));
    run_random(107);
    settle();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (k = 0; k < FRAME_COUNT; k++) frames[k] = CFG_W'({$urandom, $urandom});
    write_settings(frames, 5'($urandom), 32'hFFFF_FFFF);
    run_random(107);
    settle();

    $display("run covered %0d input words (%0d loop passes) and %0d result words",
             board.words_in, board.passes, board.words_out);
    $display("%0d readings, %0d checksum errors, %0d timeouts; %0d mismatching words",
             board.events[EV_READING], board.events[EV_CKSUM], board.events[EV_TIMEOUT],
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("tb_polled_meter_request_engine: PASS");
    end else begin
      $display("tb_polled_meter_request_engine: FAIL");
    end
    $finish;
  end

endmodule
